@@ design/ght_pkg.sv @@
// ----------------------------------------------------------------------------
// ght_pkg: shared types and constants of the generational handle table
// field widths, action and status codes, register indexes, slot entry layout
// ----------------------------------------------------------------------------
`default_nettype none

package ght_pkg;

  localparam int unsigned ACTION_W     = 3;
  localparam int unsigned INDEX_W      = 8;
  localparam int unsigned GEN_W        = 32;
  localparam int unsigned KIND_W       = 4;
  localparam int unsigned RIGHTS_W     = 16;
  localparam int unsigned PAYLOAD_W    = 64;
  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned CFG_IDX_W    = 4;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned GROUP_W      = 16;
  localparam int unsigned GROUP_LOW_W  = 4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_OPEN        = 3'd0,
    ACT_VALIDATE    = 3'd1,
    ACT_CLOSE       = 3'd2,
    ACT_PAYLOAD_SET = 3'd3,
    ACT_PAYLOAD_GET = 3'd4,
    ACT_DUP         = 3'd5
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_INVALID    = 3'd1,
    ST_FULL       = 3'd2,
    ST_BAD_HANDLE = 3'd3,
    ST_STALE      = 3'd4,
    ST_NO_PERM    = 3'd5
  } status_e;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_CAPACITY = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALID_RIGHTS  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_RIGHT   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DUP_RIGHT     = 4'd3;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [RIGHTS_W-1:0]  rights;
    logic [PAYLOAD_W-1:0] payload;
    logic [GEN_W-1:0]     generation;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  localparam slot_t SLOT_RESET = '{
    kind:       '0,
    rights:     '0,
    payload:    '0,
    generation: GEN_W'(1)
  };

endpackage

`default_nettype wire

@@ design/ght_req_if.sv @@
// ----------------------------------------------------------------------------
// ght_req_if: request channel of the generational handle table
// valid/ready handshake carrying one action and its operands
// ----------------------------------------------------------------------------
`default_nettype none

interface ght_req_if
  import ght_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [ACTION_W-1:0]    action;
  logic [INDEX_W-1:0]     handle_index;
  logic [GEN_W-1:0]       handle_generation;
  logic [KIND_W-1:0]      object_kind;
  logic [RIGHTS_W-1:0]    rights;
  logic [PAYLOAD_W-1:0]   payload_in;

  modport source (
    output valid, action, handle_index, handle_generation, object_kind, rights,
           payload_in,
    input  ready
  );

  modport sink (
    input  valid, action, handle_index, handle_generation, object_kind, rights,
           payload_in,
    output ready
  );
endinterface

`default_nettype wire

@@ design/ght_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ght_rsp_if: response channel of the generational handle table
// valid/ready handshake carrying status, new handle and payload
// ----------------------------------------------------------------------------
`default_nettype none

interface ght_rsp_if
  import ght_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [INDEX_W-1:0]     out_index;
  logic [GEN_W-1:0]       out_generation;
  logic [PAYLOAD_W-1:0]   payload_out;

  modport source (
    output valid, status, out_index, out_generation, payload_out,
    input  ready
  );

  modport sink (
    input  valid, status, out_index, out_generation, payload_out,
    output ready
  );
endinterface

`default_nettype wire

@@ design/ght_cfg_if.sv @@
// ----------------------------------------------------------------------------
// ght_cfg_if: register write channel of the generational handle table
// valid/ready handshake carrying a register index and write data
// ----------------------------------------------------------------------------
`default_nettype none

interface ght_cfg_if
  import ght_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

@@ design/ght_ram.sv @@
// ----------------------------------------------------------------------------
// ght_ram: generic synchronous ram
// one write port, two read ports, read data registered
// ----------------------------------------------------------------------------
`default_nettype none

module ght_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 256,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

@@ design/generational_handle_table.sv @@
// ----------------------------------------------------------------------------
// generational_handle_table: capability handle table with generation counters
// slot map with per-slot kind, rights, payload and generation in one ram
// ----------------------------------------------------------------------------
// usage
//   req_i carries one action per transfer: open, validate, close, payload_set,
//   payload_get or dup, with the presented handle and operands. rsp_o returns
//   exactly one result per request, in order: status, new handle, payload.
//   cfg_i writes the four registers by index; write them only while idle.
// request flow
//   a request is taken in idle; the execute step then takes the slot entry and
//   the lowest free slot entry read from the ram, checks, writes back and loads
//   the result register. a new request is taken only once the previous one has
//   finished its single read-modify-write pass over the slot ram.
// reset
//   every slot reads as free with generation 1 through per-slot written bits;
//   the block passes an init state after reset release, then takes requests.
// stall
//   a result waits in the output register; a request is still taken, and its
//   execute step holds until the waiting result has been transferred.
// ----------------------------------------------------------------------------
`default_nettype none

module generational_handle_table
  import ght_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 255
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ght_req_if.sink      req_i,
  ght_rsp_if.source    rsp_o,
  ght_cfg_if.sink      cfg_i
);

  // storage geometry; indices above 255 cannot be named by a handle
  localparam int unsigned MAX_CAP = (SLOT_COUNT < 255) ? SLOT_COUNT : 255;
  localparam int unsigned DEPTH   = MAX_CAP + 1;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned NGROUPS = (DEPTH + GROUP_W - 1) / GROUP_W;
  localparam int unsigned GW      = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
  localparam int unsigned FW      = GW + GROUP_LOW_W;
  localparam logic [INDEX_W-1:0] MAX_CAP_IDX = INDEX_W'(MAX_CAP);

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_EXEC
  } state_e;

  // handle check in the documented order
  function automatic status_e check_handle(
    input logic                out_of_range,
    input slot_t               ent,
    input logic [GEN_W-1:0]    gen,
    input logic [RIGHTS_W-1:0] need
  );
    status_e s;
    if (out_of_range) begin
      s = ST_BAD_HANDLE;
    end else if (ent.generation != gen) begin
      s = ST_STALE;
    end else if (ent.kind == '0) begin
      s = ST_BAD_HANDLE;
    end else if ((ent.rights & need) != need) begin
      s = ST_NO_PERM;
    end else begin
      s = ST_OK;
    end
    return s;
  endfunction

  state_e state_q;

  // configuration registers
  logic [INDEX_W-1:0]  cap_q, cap_d;
  logic [RIGHTS_W-1:0] vrm_q, vrm_d;
  logic [RIGHTS_W-1:0] crm_q, crm_d;
  logic [RIGHTS_W-1:0] drm_q, drm_d;
  logic [INDEX_W-1:0]  cap_eff_q, cap_eff_d;

  // per-slot flags in flops: live (kind nonzero) and written since reset
  logic [DEPTH-1:0] live_q, live_d;
  logic [DEPTH-1:0] written_q, written_d;

  // free slot search, first level registered per group of slots
  logic [NGROUPS*GROUP_W-1:0] elig;
  logic [NGROUPS-1:0]         grp_any_d, grp_any_q;
  logic [GROUP_LOW_W-1:0]     grp_low_d [NGROUPS];
  logic [GROUP_LOW_W-1:0]     grp_low_q [NGROUPS];
  logic                       free_any;
  logic [FW-1:0]              free_full;
  logic [AW-1:0]              free_idx;

  // captured request
  logic [ACTION_W-1:0]  action_q;
  logic [INDEX_W-1:0]   idx_q;
  logic [GEN_W-1:0]     gen_q;
  logic [KIND_W-1:0]    kind_q;
  logic [RIGHTS_W-1:0]  rights_q;
  logic [PAYLOAD_W-1:0] payload_q;
  logic [AW-1:0]        free_q;
  logic                 free_any_q;
  logic                 wr_a_q;
  logic                 wr_b_q;

  // result register
  logic                 rsp_valid_q;
  status_e              rsp_status_q;
  logic [INDEX_W-1:0]   rsp_index_q;
  logic [GEN_W-1:0]     rsp_gen_q;
  logic [PAYLOAD_W-1:0] rsp_payload_q;

  // ram ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  slot_t             ram_wdata;
  logic              ram_re;
  logic [SLOT_W-1:0] ram_rdata_a;
  logic [SLOT_W-1:0] ram_rdata_b;

  // execute step
  logic                 req_xfer;
  logic                 done;
  slot_t                ent_a;
  slot_t                ent_b;
  logic [AW-1:0]        idx_a;
  logic                 out_of_range;
  logic [RIGHTS_W-1:0]  need;
  status_e              chk;
  logic [KIND_W-1:0]    open_kind;
  logic                 open_bad;
  logic [GEN_W-1:0]     gen_inc;
  logic [GEN_W-1:0]     gen_next;
  status_e              st;
  logic                 do_alloc;
  logic                 do_close;
  logic                 do_set;
  logic                 get_ok;

  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign req_xfer    = req_i.valid && req_i.ready;

  // ---------------------------------------------------------------- registers
  always_comb begin
    cap_d = cap_q;
    vrm_d = vrm_q;
    crm_d = crm_q;
    drm_d = drm_q;
    if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        CFG_SLOT_CAPACITY: cap_d = cfg_i.data[INDEX_W-1:0];
        CFG_VALID_RIGHTS:  vrm_d = cfg_i.data[RIGHTS_W-1:0];
        CFG_CLOSE_RIGHT:   crm_d = cfg_i.data[RIGHTS_W-1:0];
        CFG_DUP_RIGHT:     drm_d = cfg_i.data[RIGHTS_W-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  assign cap_eff_d = (cap_d < MAX_CAP_IDX) ? cap_d : MAX_CAP_IDX;
  assign cap_eff_q = (cap_q < MAX_CAP_IDX) ? cap_q : MAX_CAP_IDX;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= INDEX_W'(255);
      vrm_q <= RIGHTS_W'(16'hffff);
      crm_q <= RIGHTS_W'(1);
      drm_q <= RIGHTS_W'(2);
    end else begin
      cap_q <= cap_d;
      vrm_q <= vrm_d;
      crm_q <= crm_d;
      drm_q <= drm_d;
    end
  end

  // ---------------------------------------------------------- free slot search
  // first level works on next-state flags so the result is current in idle
  always_comb begin
    elig = '0;
    for (int p = 1; p < int'(DEPTH); p++) begin
      elig[p] = !live_d[p] && (p <= int'(cap_eff_d));
    end
  end

  always_comb begin
    for (int g = 0; g < int'(NGROUPS); g++) begin
      grp_any_d[g] = |elig[g*GROUP_W +: GROUP_W];
      grp_low_d[g] = '0;
      for (int b = int'(GROUP_W) - 1; b >= 0; b--) begin
        if (elig[g*GROUP_W + b]) begin
          grp_low_d[g] = GROUP_LOW_W'(b);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_any_q <= grp_any_d;
    for (int g = 0; g < int'(NGROUPS); g++) begin
      grp_low_q[g] <= grp_low_d[g];
    end
  end

  // second level: lowest group holding a free slot
  always_comb begin
    free_any  = |grp_any_q;
    free_full = '0;
    for (int g = int'(NGROUPS) - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        free_full = {GW'(g), grp_low_q[g]};
      end
    end
  end

  assign free_idx = free_full[AW-1:0];

  // ------------------------------------------------------------ request latch
  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      action_q   <= req_i.action;
      idx_q      <= req_i.handle_index;
      gen_q      <= req_i.handle_generation;
      kind_q     <= req_i.object_kind;
      rights_q   <= req_i.rights;
      payload_q  <= req_i.payload_in;
      free_q     <= free_idx;
      free_any_q <= free_any;
      wr_a_q     <= written_q[req_i.handle_index[AW-1:0]];
      wr_b_q     <= written_q[free_idx];
    end
  end

  // -------------------------------------------------------------- slot memory
  // port a: presented handle, port b: lowest free slot
  assign ram_re = req_xfer;

  ght_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (ram_re),
    .raddr_a_i (req_i.handle_index[AW-1:0]),
    .raddr_b_i (free_idx),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  // entries never written since reset read as free, generation 1
  assign ent_a = wr_a_q ? slot_t'(ram_rdata_a) : SLOT_RESET;
  assign ent_b = wr_b_q ? slot_t'(ram_rdata_b) : SLOT_RESET;

  // ------------------------------------------------------------- execute step
  assign done         = (state_q == S_EXEC) && (!rsp_valid_q || rsp_o.ready);
  assign idx_a        = idx_q[AW-1:0];
  assign out_of_range = (idx_q == '0) || (idx_q > cap_eff_q);

  always_comb begin
    unique case (action_q)
      ACT_VALIDATE: need = rights_q;
      ACT_DUP:      need = drm_q;
      default:      need = crm_q;
    endcase
  end

  assign chk       = check_handle(out_of_range, ent_a, gen_q, need);
  assign open_kind = (action_q == ACT_DUP) ? ent_a.kind : kind_q;
  assign open_bad  = (open_kind == '0) || ((rights_q & ~vrm_q) != '0);
  assign gen_inc   = ent_a.generation + GEN_W'(1);
  // generation wraps and skips zero
  assign gen_next  = (gen_inc == '0) ? GEN_W'(1) : gen_inc;

  always_comb begin
    st       = ST_INVALID;
    do_alloc = 1'b0;
    do_close = 1'b0;
    do_set   = 1'b0;
    get_ok   = 1'b0;
    unique case (action_q)
      ACT_OPEN: begin
        if (open_bad) begin
          st = ST_INVALID;
        end else if (!free_any_q) begin
          st = ST_FULL;
        end else begin
          st       = ST_OK;
          do_alloc = 1'b1;
        end
      end
      ACT_VALIDATE: begin
        st = chk;
      end
      ACT_CLOSE: begin
        st       = chk;
        do_close = (chk == ST_OK);
      end
      ACT_PAYLOAD_SET: begin
        st = chk;
        if (chk == ST_OK) begin
          if ((ent_a.kind != kind_q) || (payload_q == '0)) begin
            st = ST_INVALID;
          end else begin
            do_set = 1'b1;
          end
        end
      end
      ACT_PAYLOAD_GET: begin
        st = chk;
        if (chk == ST_OK) begin
          if ((ent_a.kind != kind_q) || (ent_a.payload == '0)) begin
            st = ST_INVALID;
          end else begin
            get_ok = 1'b1;
          end
        end
      end
      ACT_DUP: begin
        st = chk;
        if (chk == ST_OK) begin
          // rights may only narrow, then it behaves as open
          if ((rights_q & ~ent_a.rights) != '0) begin
            st = ST_NO_PERM;
          end else if (open_bad) begin
            st = ST_INVALID;
          end else if (!free_any_q) begin
            st = ST_FULL;
          end else begin
            st       = ST_OK;
            do_alloc = 1'b1;
          end
        end
      end
      default: begin
        st = ST_INVALID;
      end
    endcase
  end

  // write back: one entry per request at most
  always_comb begin
    ram_we    = done && (do_alloc || do_close || do_set);
    ram_waddr = idx_a;
    ram_wdata = ent_a;
    if (do_alloc) begin
      // new slot keeps its payload and generation
      ram_waddr            = free_q;
      ram_wdata            = ent_b;
      ram_wdata.kind       = open_kind;
      ram_wdata.rights     = rights_q;
    end else if (do_close) begin
      ram_wdata            = SLOT_RESET;
      ram_wdata.generation = gen_next;
    end else begin
      ram_wdata.payload    = payload_q;
    end
  end

  always_comb begin
    live_d    = live_q;
    written_d = written_q;
    if (ram_we) begin
      written_d[ram_waddr] = 1'b1;
    end
    if (done && do_alloc) begin
      live_d[free_q] = 1'b1;
    end
    if (done && do_close) begin
      live_d[idx_a] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q    <= '0;
      written_q <= '0;
    end else begin
      live_q    <= live_d;
      written_q <= written_d;
    end
  end

  // ---------------------------------------------- control and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_INIT;
      rsp_valid_q   <= 1'b0;
      rsp_status_q  <= ST_OK;
      rsp_index_q   <= '0;
      rsp_gen_q     <= '0;
      rsp_payload_q <= '0;
    end else begin
      // a new result replaces the one leaving in the same cycle
      if (done) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_INIT: begin
          // the init state lets the free slot search settle before idle
          state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (req_xfer) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (done) begin
            state_q       <= S_IDLE;
            rsp_status_q  <= st;
            rsp_index_q   <= do_alloc ? INDEX_W'(free_q) : '0;
            rsp_gen_q     <= do_alloc ? ent_b.generation : '0;
            rsp_payload_q <= get_ok ? ent_a.payload : '0;
          end
        end
        default: begin
          state_q <= S_INIT;
        end
      endcase
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.status         = rsp_status_q;
  assign rsp_o.out_index      = rsp_index_q;
  assign rsp_o.out_generation = rsp_gen_q;
  assign rsp_o.payload_out    = rsp_payload_q;

  // --------------------------------------------------------------- assertions
`ifndef SYNTHESIS
  // a result only appears out of an execute step
  a_rsp_from_exec: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == S_EXEC)
  ) else $error("result raised without an execute step");

  // a new handle never carries generation zero
  a_new_gen_nonzero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && (rsp_status_q == ST_OK) && (rsp_index_q != '0)) |-> (rsp_gen_q != '0)
  ) else $error("new handle with generation zero");

  // slot zero is never written
  a_no_slot_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ram_waddr != '0)
  ) else $error("write to slot zero");

  // an allocated slot is marked live afterwards
  a_alloc_live: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (ram_we && do_alloc) |=> live_q[$past(free_q)]
  ) else $error("allocated slot not live");
`endif

endmodule

`default_nettype wire
